/* rtl/ctt_pkg.sv */
// Shared types, widths and constants of the cycle counter timekeeper.
package ctt_pkg;

    localparam int CYCLE_W     = 32;
    localparam int SEC_W       = 32;
    localparam int USEC_W      = 20;
    localparam int RATE_W      = 48;
    localparam int TICKLEN_W   = 20;
    localparam int TICKS_W     = 16;
    localparam int RUSEC_W     = 21;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 48;

    localparam int MUL_W       = 32;
    localparam int MPROD_W     = 2 * MUL_W;
    localparam int PROD_W      = CYCLE_W + RATE_W;
    localparam int FACTOR_W    = 14;
    localparam int SUM_W       = PROD_W + FACTOR_W;
    localparam int SCALE_BITS  = 48;
    localparam int QUO_W       = SUM_W - (SCALE_BITS - 6);
    localparam int USUM_W      = QUO_W + 1;
    localparam int DIV_STEPS   = 4;
    localparam int DIV_CYCLES  = QUO_W / DIV_STEPS;
    localparam int DIV_CNT_W   = $clog2(DIV_CYCLES);

    localparam logic [SEC_W:0]       RTC_MIN_GAP    = 33'd660;
    localparam logic [SEC_W-1:0]     RTC_BACKOFF    = 32'd600;
    localparam logic [RUSEC_W:0]     RTC_MID_USEC   = 22'd500000;
    localparam logic [MUL_W-1:0]     USEC_FACTOR    = 32'd15625;
    localparam logic [USUM_W-1:0]    USEC_PER_SEC   = 53'd1000000;
    localparam logic [TICKLEN_W-1:0] TICK_LEN_RESET = 20'd976;
    localparam logic [TICKS_W-1:0]   TICKS_MAX      = 16'hFFFF;
    localparam logic [RUSEC_W-1:0]   RUSEC_MAX      = 21'h1FFFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCALED_TICK_RATE = 1'b0,
        CFG_TICK_LENGTH_USEC = 1'b1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        REQ_START   = 2'd0,
        REQ_TICK    = 2'd1,
        REQ_READ    = 2'd2,
        REQ_OUTCOME = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        MS_DELTA_LO,
        MS_DELTA_HI,
        MS_PROD_0,
        MS_PROD_1,
        MS_PROD_2
    } mul_sel_t;

    typedef enum logic [2:0] {
        ACC_NONE,
        ACC_P_SET,
        ACC_P_ADD32,
        ACC_S_SET,
        ACC_S_ADD32,
        ACC_S_ADD64
    } acc_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_ACC_HI,
        ST_TICK_OUT,
        ST_RMUL_0,
        ST_RMUL_1,
        ST_RMUL_2,
        ST_RACC_2,
        ST_DIV_LOAD,
        ST_DIV,
        ST_RSUM,
        ST_READ_OUT
    } state_t;

    typedef struct packed {
        logic     accept;
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
        logic     div_load;
        logic     div_step;
        logic     sum_en;
        logic     out_tick;
        logic     out_read;
    } cmd_t;

    typedef struct packed {
        logic item_is_tick;
        logic out_free;
    } status_t;

endpackage

/* rtl/ctt_ifs.sv */
// Valid/ready channel interfaces for input items and result items.
interface ctt_item_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   req_type;
    logic [ctt_pkg::CYCLE_W-1:0]  cycle_count;
    logic [ctt_pkg::SEC_W-1:0]    clock_sec;
    logic [ctt_pkg::USEC_W-1:0]   clock_usec;
    logic                         clock_synced;
    logic                         rtc_write_failed;

    modport source (
        output valid, req_type, cycle_count, clock_sec, clock_usec, clock_synced,
               rtc_write_failed,
        input  ready
    );
    modport sink (
        input  valid, req_type, cycle_count, clock_sec, clock_usec, clock_synced,
               rtc_write_failed,
        output ready
    );
endinterface

interface ctt_result_if;
    logic                         valid;
    logic                         ready;
    logic [ctt_pkg::TICKS_W-1:0]  tick_count;
    logic                         rtc_update_request;
    logic [ctt_pkg::SEC_W-1:0]    rtc_write_sec;
    logic [ctt_pkg::SEC_W-1:0]    read_sec;
    logic [ctt_pkg::RUSEC_W-1:0]  read_usec;

    modport source (
        output valid, tick_count, rtc_update_request, rtc_write_sec, read_sec, read_usec,
        input  ready
    );
    modport sink (
        input  valid, tick_count, rtc_update_request, rtc_write_sec, read_sec, read_usec,
        output ready
    );
endinterface

/* rtl/cycle_counter_tick_timekeeper_core.sv */
// Top level of the cycle counter timekeeper: controller and datapath.
// Start capture and write outcome items are taken while idle and give no result.
// A timer tick item gives its result when TICK_OUT finds the result register free; the next
// item is taken then. A time read item uses one shared 32x32 multiplier for its products
// and the divide by TICK_RATE_HZ resolves 4 bits a cycle.
// Reset clears the state, sets the tick length register to 976 and leaves no result pending.
module cycle_counter_tick_timekeeper_core #(
    parameter int TICK_RATE_HZ = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    ctt_item_if.sink                        item_in,
    ctt_result_if.source                    result_out,
    input  logic                            cfg_we,
    input  logic [ctt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ctt_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    ctt_pkg::cmd_t    cmd;
    ctt_pkg::status_t status;
    ctt_pkg::req_t    in_req;
    logic             in_ready;

    assign in_req        = ctt_pkg::req_t'(item_in.req_type);
    assign item_in.ready = in_ready;

    ctt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item_in.valid),
        .in_req   (in_req),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    ctt_datapath #(
        .TICK_RATE_HZ (TICK_RATE_HZ)
    ) u_datapath (
        .clk                    (clk),
        .rst_n                  (rst_n),
        .cfg_we                 (cfg_we),
        .cfg_index              (cfg_index),
        .cfg_wdata              (cfg_wdata),
        .in_req                 (in_req),
        .in_cycle_count         (item_in.cycle_count),
        .in_clock_sec           (item_in.clock_sec),
        .in_clock_usec          (item_in.clock_usec),
        .in_clock_synced        (item_in.clock_synced),
        .in_rtc_write_failed    (item_in.rtc_write_failed),
        .cmd                    (cmd),
        .status                 (status),
        .out_ready              (result_out.ready),
        .out_valid              (result_out.valid),
        .out_tick_count         (result_out.tick_count),
        .out_rtc_update_request (result_out.rtc_update_request),
        .out_rtc_write_sec      (result_out.rtc_write_sec),
        .out_read_sec           (result_out.read_sec),
        .out_read_usec          (result_out.read_usec)
    );

endmodule

/* rtl/ctt_ctrl.sv */
// Sequencing state machine of the timekeeper.
module ctt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  ctt_pkg::req_t     in_req,
    output logic              in_ready,
    input  ctt_pkg::status_t  status,
    output ctt_pkg::cmd_t     cmd
);

    ctt_pkg::state_t                 state_reg;
    ctt_pkg::state_t                 state_next;
    logic [ctt_pkg::DIV_CNT_W-1:0]   div_cnt_reg;
    logic [ctt_pkg::DIV_CNT_W-1:0]   div_cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ctt_pkg::ST_IDLE;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        in_ready     = 1'b0;
        cmd          = '{accept: 1'b0, mul_sel: ctt_pkg::MS_DELTA_LO,
                         acc_op: ctt_pkg::ACC_NONE, div_load: 1'b0, div_step: 1'b0,
                         sum_en: 1'b0, out_tick: 1'b0, out_read: 1'b0};
        unique case (state_reg)
            ctt_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (in_req inside {ctt_pkg::REQ_TICK, ctt_pkg::REQ_READ})
                    begin
                        state_next = ctt_pkg::ST_MUL_LO;
                    end
                end
            end
            ctt_pkg::ST_MUL_LO:
            begin
                cmd.mul_sel = ctt_pkg::MS_DELTA_LO;
                state_next  = ctt_pkg::ST_MUL_HI;
            end
            ctt_pkg::ST_MUL_HI:
            begin
                cmd.mul_sel = ctt_pkg::MS_DELTA_HI;
                cmd.acc_op  = ctt_pkg::ACC_P_SET;
                state_next  = ctt_pkg::ST_ACC_HI;
            end
            ctt_pkg::ST_ACC_HI:
            begin
                cmd.acc_op = ctt_pkg::ACC_P_ADD32;
                state_next = status.item_is_tick ? ctt_pkg::ST_TICK_OUT : ctt_pkg::ST_RMUL_0;
            end
            ctt_pkg::ST_TICK_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_tick = 1'b1;
                    state_next   = ctt_pkg::ST_IDLE;
                end
            end
            ctt_pkg::ST_RMUL_0:
            begin
                cmd.mul_sel = ctt_pkg::MS_PROD_0;
                state_next  = ctt_pkg::ST_RMUL_1;
            end
            ctt_pkg::ST_RMUL_1:
            begin
                cmd.mul_sel = ctt_pkg::MS_PROD_1;
                cmd.acc_op  = ctt_pkg::ACC_S_SET;
                state_next  = ctt_pkg::ST_RMUL_2;
            end
            ctt_pkg::ST_RMUL_2:
            begin
                cmd.mul_sel = ctt_pkg::MS_PROD_2;
                cmd.acc_op  = ctt_pkg::ACC_S_ADD32;
                state_next  = ctt_pkg::ST_RACC_2;
            end
            ctt_pkg::ST_RACC_2:
            begin
                cmd.acc_op = ctt_pkg::ACC_S_ADD64;
                state_next = ctt_pkg::ST_DIV_LOAD;
            end
            ctt_pkg::ST_DIV_LOAD:
            begin
                cmd.div_load = 1'b1;
                div_cnt_next = '0;
                state_next   = ctt_pkg::ST_DIV;
            end
            ctt_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (div_cnt_reg == ctt_pkg::DIV_CNT_W'(ctt_pkg::DIV_CYCLES - 1))
                begin
                    div_cnt_next = '0;
                    state_next   = ctt_pkg::ST_RSUM;
                end
                else
                begin
                    div_cnt_next = div_cnt_reg + 1'b1;
                end
            end
            ctt_pkg::ST_RSUM:
            begin
                cmd.sum_en = 1'b1;
                state_next = ctt_pkg::ST_READ_OUT;
            end
            ctt_pkg::ST_READ_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_read = 1'b1;
                    state_next   = ctt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ctt_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/ctt_datapath.sv */
// Datapath of the timekeeper: registers, shared multiplier, divider and result register.
module ctt_datapath #(
    parameter int TICK_RATE_HZ = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [ctt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ctt_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  ctt_pkg::req_t                    in_req,
    input  logic [ctt_pkg::CYCLE_W-1:0]      in_cycle_count,
    input  logic [ctt_pkg::SEC_W-1:0]        in_clock_sec,
    input  logic [ctt_pkg::USEC_W-1:0]       in_clock_usec,
    input  logic                             in_clock_synced,
    input  logic                             in_rtc_write_failed,
    input  ctt_pkg::cmd_t                    cmd,
    output ctt_pkg::status_t                 status,
    input  logic                             out_ready,
    output logic                             out_valid,
    output logic [ctt_pkg::TICKS_W-1:0]      out_tick_count,
    output logic                             out_rtc_update_request,
    output logic [ctt_pkg::SEC_W-1:0]        out_rtc_write_sec,
    output logic [ctt_pkg::SEC_W-1:0]        out_read_sec,
    output logic [ctt_pkg::RUSEC_W-1:0]      out_read_usec
);

    localparam int REM_W = $clog2(TICK_RATE_HZ) + 1;
    localparam logic [REM_W:0] DIVISOR = (REM_W + 1)'(TICK_RATE_HZ);

    logic [ctt_pkg::RATE_W-1:0]     rate_reg;
    logic [ctt_pkg::TICKLEN_W-1:0]  tick_len_reg;
    logic [ctt_pkg::CYCLE_W-1:0]    last_cycle_reg;
    logic [ctt_pkg::SEC_W-1:0]      last_rtc_reg;
    logic                           out_valid_reg;

    ctt_pkg::req_t                  req_reg;
    logic [ctt_pkg::CYCLE_W-1:0]    delta_reg;
    logic [ctt_pkg::SEC_W-1:0]      csec_reg;
    logic [ctt_pkg::USEC_W-1:0]     cusec_reg;
    logic                           synced_reg;

    logic [ctt_pkg::MUL_W-1:0]      mul_a;
    logic [ctt_pkg::MUL_W-1:0]      mul_b;
    logic [ctt_pkg::MPROD_W-1:0]    prod_next;
    logic [ctt_pkg::MPROD_W-1:0]    prod_reg;
    logic [ctt_pkg::PROD_W-1:0]     p_reg;
    logic [ctt_pkg::SUM_W-1:0]      s_reg;
    logic [ctt_pkg::QUO_W-1:0]      quo_reg;
    logic [REM_W-1:0]               rem_reg;
    logic [ctt_pkg::QUO_W-1:0]      quo_next;
    logic [REM_W-1:0]               rem_next;
    logic [REM_W:0]                 trial;
    logic [ctt_pkg::USUM_W-1:0]     usum_reg;
    logic [ctt_pkg::USUM_W-1:0]     usum_next;
    logic [ctt_pkg::QUO_W:0]        quo_inc;

    logic [ctt_pkg::SEC_W-1:0]      last_rtc_backoff;
    logic [ctt_pkg::SEC_W-1:0]      whole;
    logic [ctt_pkg::SCALE_BITS-1:0] frac;
    logic                           round_up;
    logic [ctt_pkg::SEC_W:0]        whole_rnd;
    logic [ctt_pkg::TICKS_W-1:0]    tick_val;
    logic [ctt_pkg::TICKLEN_W-1:0]  half_tick;
    logic signed [ctt_pkg::RUSEC_W:0] win_lo;
    logic [ctt_pkg::RUSEC_W-1:0]    win_hi;
    logic                           rtc_req;
    logic [ctt_pkg::SEC_W-1:0]      rsec_val;
    logic [ctt_pkg::USUM_W-1:0]     rusec_wide;
    logic [ctt_pkg::RUSEC_W-1:0]    rusec_val;

    assign status.item_is_tick = (req_reg == ctt_pkg::REQ_TICK);
    assign status.out_free     = !out_valid_reg || out_ready;
    assign out_valid           = out_valid_reg;

    always_comb
    begin
        case (cmd.mul_sel)
            ctt_pkg::MS_DELTA_LO:
            begin
                mul_a = delta_reg;
                mul_b = rate_reg[ctt_pkg::MUL_W-1:0];
            end
            ctt_pkg::MS_DELTA_HI:
            begin
                mul_a = delta_reg;
                mul_b = ctt_pkg::MUL_W'(rate_reg[ctt_pkg::RATE_W-1:ctt_pkg::MUL_W]);
            end
            ctt_pkg::MS_PROD_0:
            begin
                mul_a = p_reg[ctt_pkg::MUL_W-1:0];
                mul_b = ctt_pkg::USEC_FACTOR;
            end
            ctt_pkg::MS_PROD_1:
            begin
                mul_a = p_reg[2*ctt_pkg::MUL_W-1:ctt_pkg::MUL_W];
                mul_b = ctt_pkg::USEC_FACTOR;
            end
            ctt_pkg::MS_PROD_2:
            begin
                mul_a = ctt_pkg::MUL_W'(p_reg[ctt_pkg::PROD_W-1:2*ctt_pkg::MUL_W]);
                mul_b = ctt_pkg::USEC_FACTOR;
            end
            default:
            begin
                mul_a = delta_reg;
                mul_b = rate_reg[ctt_pkg::MUL_W-1:0];
            end
        endcase
        prod_next = mul_a * mul_b;
    end

    always_comb
    begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        trial    = '0;
        for (int i = 0; i < ctt_pkg::DIV_STEPS; i++)
        begin
            trial    = {rem_next, quo_next[ctt_pkg::QUO_W-1]};
            quo_next = {quo_next[ctt_pkg::QUO_W-2:0], 1'b0};
            if (trial >= DIVISOR)
            begin
                rem_next    = REM_W'(trial - DIVISOR);
                quo_next[0] = 1'b1;
            end
            else
            begin
                rem_next = trial[REM_W-1:0];
            end
        end
    end

    always_comb
    begin
        quo_inc   = {1'b0, quo_reg} + 1'b1;
        usum_next = {1'b0, quo_inc[ctt_pkg::QUO_W:1]} + ctt_pkg::USUM_W'(cusec_reg);
        if (usum_reg >= ctt_pkg::USEC_PER_SEC)
        begin
            rsec_val   = csec_reg + 1'b1;
            rusec_wide = usum_reg - ctt_pkg::USEC_PER_SEC;
        end
        else
        begin
            rsec_val   = csec_reg;
            rusec_wide = usum_reg;
        end
        if (rusec_wide > ctt_pkg::USUM_W'(ctt_pkg::RUSEC_MAX))
        begin
            rusec_val = ctt_pkg::RUSEC_MAX;
        end
        else
        begin
            rusec_val = rusec_wide[ctt_pkg::RUSEC_W-1:0];
        end
    end

    always_comb
    begin
        whole     = p_reg[ctt_pkg::PROD_W-1:ctt_pkg::SCALE_BITS];
        frac      = p_reg[ctt_pkg::SCALE_BITS-1:0];
        round_up  = (frac > {1'b1, {(ctt_pkg::SCALE_BITS-1){1'b0}}})
                    || ((frac == {1'b1, {(ctt_pkg::SCALE_BITS-1){1'b0}}}) && whole[0]);
        whole_rnd = {1'b0, whole} + (ctt_pkg::SEC_W + 1)'(round_up);
        if (whole_rnd == '0)
        begin
            tick_val = ctt_pkg::TICKS_W'(1);
        end
        else if (whole_rnd > (ctt_pkg::SEC_W + 1)'(ctt_pkg::TICKS_MAX))
        begin
            tick_val = ctt_pkg::TICKS_MAX;
        end
        else
        begin
            tick_val = whole_rnd[ctt_pkg::TICKS_W-1:0];
        end

        half_tick = tick_len_reg >> 1;
        win_lo    = $signed(ctt_pkg::RTC_MID_USEC) - $signed({2'b00, half_tick});
        win_hi    = ctt_pkg::RTC_MID_USEC[ctt_pkg::RUSEC_W-1:0] + {1'b0, half_tick};
        rtc_req   = synced_reg
                    && ({1'b0, csec_reg} > ({1'b0, last_rtc_reg} + ctt_pkg::RTC_MIN_GAP))
                    && ($signed({2'b00, cusec_reg}) >= win_lo)
                    && ({1'b0, cusec_reg} <= win_hi);

        last_rtc_backoff = (last_rtc_reg >= ctt_pkg::RTC_BACKOFF)
                           ? last_rtc_reg - ctt_pkg::RTC_BACKOFF : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg       <= '0;
            tick_len_reg   <= ctt_pkg::TICK_LEN_RESET;
            last_cycle_reg <= '0;
            last_rtc_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (ctt_pkg::cfg_idx_t'(cfg_index))
                    ctt_pkg::CFG_SCALED_TICK_RATE: rate_reg <= cfg_wdata;
                    ctt_pkg::CFG_TICK_LENGTH_USEC:
                        tick_len_reg <= cfg_wdata[ctt_pkg::TICKLEN_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.accept)
            begin
                unique case (in_req)
                    ctt_pkg::REQ_START:
                    begin
                        last_cycle_reg <= in_cycle_count;
                        last_rtc_reg   <= '0;
                    end
                    ctt_pkg::REQ_TICK:
                    begin
                        last_cycle_reg <= in_cycle_count;
                    end
                    ctt_pkg::REQ_READ: ;
                    ctt_pkg::REQ_OUTCOME:
                    begin
                        if (in_rtc_write_failed)
                        begin
                            last_rtc_reg <= last_rtc_backoff;
                        end
                    end
                    default: ;
                endcase
            end
            if (cmd.out_tick && rtc_req)
            begin
                last_rtc_reg <= csec_reg;
            end
            if (cmd.out_tick || cmd.out_read)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (cmd.accept)
        begin
            req_reg    <= in_req;
            delta_reg  <= in_cycle_count - last_cycle_reg;
            csec_reg   <= in_clock_sec;
            cusec_reg  <= in_clock_usec;
            synced_reg <= in_clock_synced;
        end
        case (cmd.acc_op)
            ctt_pkg::ACC_P_SET:
                p_reg <= ctt_pkg::PROD_W'(prod_reg);
            ctt_pkg::ACC_P_ADD32:
                p_reg <= p_reg + {prod_reg[ctt_pkg::PROD_W-ctt_pkg::MUL_W-1:0],
                                  {ctt_pkg::MUL_W{1'b0}}};
            ctt_pkg::ACC_S_SET:
                s_reg <= ctt_pkg::SUM_W'(prod_reg);
            ctt_pkg::ACC_S_ADD32:
                s_reg <= s_reg + {prod_reg[ctt_pkg::SUM_W-ctt_pkg::MUL_W-1:0],
                                  {ctt_pkg::MUL_W{1'b0}}};
            ctt_pkg::ACC_S_ADD64:
                s_reg <= s_reg + {prod_reg[ctt_pkg::SUM_W-2*ctt_pkg::MUL_W-1:0],
                                  {(2*ctt_pkg::MUL_W){1'b0}}};
            default: ;
        endcase
        if (cmd.div_load)
        begin
            quo_reg <= s_reg[ctt_pkg::SUM_W-1:ctt_pkg::SUM_W-ctt_pkg::QUO_W];
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
        if (cmd.sum_en)
        begin
            usum_reg <= usum_next;
        end
        if (cmd.out_tick)
        begin
            out_tick_count         <= tick_val;
            out_rtc_update_request <= rtc_req;
            out_rtc_write_sec      <= rtc_req ? csec_reg : '0;
            out_read_sec           <= '0;
            out_read_usec          <= '0;
        end
        else if (cmd.out_read)
        begin
            out_tick_count         <= '0;
            out_rtc_update_request <= 1'b0;
            out_rtc_write_sec      <= '0;
            out_read_sec           <= rsec_val;
            out_read_usec          <= rusec_val;
        end
    end

endmodule

/* rtl/ctt_checker.sv */
// Port-level assertions for the timekeeper top level and their binding.
module ctt_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic [1:0]                     in_req_type,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic [ctt_pkg::TICKS_W-1:0]    tick_count,
    input  logic                           rtc_update_request,
    input  logic [ctt_pkg::SEC_W-1:0]      rtc_write_sec,
    input  logic [ctt_pkg::SEC_W-1:0]      read_sec,
    input  logic [ctt_pkg::RUSEC_W-1:0]    read_usec
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("A stalled result item was withdrawn.");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(tick_count) && $stable(read_sec)
                                    && $stable(read_usec) && $stable(rtc_write_sec))
        else $error("A stalled result item changed.");

    a_busy_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready
        && (in_req_type == ctt_pkg::REQ_TICK || in_req_type == ctt_pkg::REQ_READ)
        |=> !in_ready)
        else $error("A new item was taken while a tick or read item was in progress.");

    a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (tick_count != '0 && read_sec == '0 && read_usec == '0)
                      || (tick_count == '0 && !rtc_update_request && rtc_write_sec == '0))
        else $error("A result item mixes tick and read fields.");

    a_rtc_sec: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !rtc_update_request |-> rtc_write_sec == '0)
        else $error("An RTC second was given without an update request.");

endmodule

bind cycle_counter_tick_timekeeper_core ctt_checker u_ctt_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (item_in.valid),
    .in_ready           (item_in.ready),
    .in_req_type        (item_in.req_type),
    .out_valid          (result_out.valid),
    .out_ready          (result_out.ready),
    .tick_count         (result_out.tick_count),
    .rtc_update_request (result_out.rtc_update_request),
    .rtc_write_sec      (result_out.rtc_write_sec),
    .read_sec           (result_out.read_sec),
    .read_usec          (result_out.read_usec)
);
